### rtl/lom_pkg.sv
// Package with the shared types and constants of the limit order matcher.
`default_nettype none
package lom_pkg;
   localparam int BookDepth = 32;
   localparam int IdxW = $clog2(BookDepth);
   localparam int CntW = $clog2(BookDepth + 1);

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CANCEL = 1'b1;
   localparam logic SIDE_BUY = 1'b0;

   localparam logic [2:0] KIND_TRADE = 3'd0;
   localparam logic [2:0] KIND_DONE = 3'd1;
   localparam logic [2:0] KIND_RESTED = 3'd2;
   localparam logic [2:0] KIND_FULL = 3'd3;
   localparam logic [2:0] KIND_CANCELLED = 3'd4;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic        operation;
      logic        side;
      logic        order_type;
      logic [31:0] order_id;
      logic [31:0] limit_price;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] buyer_id;
      logic [31:0] seller_id;
      logic [31:0] trade_price;
      logic [31:0] amount;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request
      logic fill;    // fill against the head of the opposite book
      logic rest;    // insert the remainder into its own book
      logic cancel;  // remove the matching order
      logic emit;    // present a result on the output register
      logic [2:0] kind;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_cancel;
      logic is_market;
      logic crosses;    // rem > 0, opposite head valid and price crosses
      logic rem_zero;
      logic own_full;
      logic found;
      logic out_busy;
   } sts_type;
endpackage
`default_nettype wire

### rtl/limit_order_matcher_core.sv
// Top level of the price-time priority limit order matcher.
// A request (add or cancel) enters on req_valid/req_ready and is held in
// a request register. Each result leaves on rsp_valid/rsp_ready from an
// output register; last marks the final result of a request.
// An add emits one trade per cycle while it crosses the opposite book
// and the output register is free, then one completion (done, rested or
// dropped as book full). A cancel emits one result. A request is loaded
// on acceptance, then its results are emitted one by one, each set by the
// single result register, before the next request is accepted. Insert and
// cancel each shift the sorted cell row of a book.
// When the receiver stalls, the controller holds until the output
// register is free, so no result is lost. Reset clears both books'
// valid bits and the controller; entry contents need no clearing.
// Each book holds BookDepth orders.
`default_nettype none
module limit_order_matcher_core
   import lom_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   cmd_type cmd;
   sts_type sts;

   lom_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   lom_datapath u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

### rtl/lom_datapath.sv
// Datapath of the limit order matcher: both books as shifting sorted cell rows.
`default_nettype none
module lom_datapath
   import lom_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   // Book 0 holds bids, book 1 holds asks.
   logic [BookDepth-1:0] vld_ff [2];
   logic [BookDepth-1:0] vld_in [2];
   logic [31:0] id_ff [2][BookDepth];
   logic [31:0] px_ff [2][BookDepth];
   logic [31:0] lf_ff [2][BookDepth];
   req_type q_ff;
   logic [31:0] rem_ff;
   rsp_type out_ff;
   logic out_v_ff;

   logic opp, own;
   logic [31:0] head_px, head_lf, fill_q;
   logic cross_px;
   logic [BookDepth-1:0] hit [2];
   logic [BookDepth-1:0] ins_before;
   logic cbook;

   assign opp = ~q_ff.side;
   assign own = q_ff.side;
   assign head_px = px_ff[opp][0];
   assign head_lf = lf_ff[opp][0];
   assign fill_q = (rem_ff < head_lf) ? rem_ff : head_lf;
   assign cross_px = q_ff.order_type ? 1'b1 :
      ((q_ff.side == SIDE_BUY) ? (q_ff.limit_price >= head_px) : (head_px >= q_ff.limit_price));

   always_comb begin
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < BookDepth; i++)
            hit[b][i] = vld_ff[b][i] && (id_ff[b][i] == q_ff.order_id);
      // Position is after every entry of equal or better price.
      for (int i = 0; i < BookDepth; i++)
         ins_before[i] = vld_ff[own][i] && ((q_ff.side == SIDE_BUY) ?
            (px_ff[own][i] >= q_ff.limit_price) : (px_ff[own][i] <= q_ff.limit_price));
   end
   assign cbook = (hit[0] == '0);

   assign sts.is_cancel = (q_ff.operation == OP_CANCEL);
   assign sts.is_market = q_ff.order_type;
   assign sts.rem_zero = (rem_ff == 32'd0);
   assign sts.crosses = (rem_ff != 32'd0) && vld_ff[opp][0] && cross_px;
   assign sts.own_full = vld_ff[own][BookDepth-1];
   assign sts.found = (hit[0] != '0) || (hit[1] != '0);
   assign sts.out_busy = out_v_ff && !rsp_ready;

   // Prefix masks for cancel: entries at or after the first hit shift down.
   logic [BookDepth-1:0] at_or_after;
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < BookDepth; i++) begin
         seen = seen | hit[cbook][i];
         at_or_after[i] = seen;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.fill && fill_q == head_lf)
         vld_in[opp] = vld_ff[opp] >> 1;
      if (cmd.rest)
         vld_in[own] = {vld_ff[own][BookDepth-2:0], 1'b1};
      if (cmd.cancel && sts.found)
         vld_in[cbook] = vld_ff[cbook] >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= '0;
         vld_ff[1] <= '0;
         out_v_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (cmd.emit)
            out_v_ff <= 1'b1;
         else if (rsp_ready)
            out_v_ff <= 1'b0;
      end
      if (cmd.load) begin
         q_ff <= req_data;
         rem_ff <= req_data.quantity;
      end
      if (cmd.fill) begin
         rem_ff <= rem_ff - fill_q;
         if (fill_q == head_lf) begin
            for (int i = 0; i < BookDepth - 1; i++) begin
               id_ff[opp][i] <= id_ff[opp][i+1];
               px_ff[opp][i] <= px_ff[opp][i+1];
               lf_ff[opp][i] <= lf_ff[opp][i+1];
            end
         end else begin
            lf_ff[opp][0] <= head_lf - fill_q;
         end
      end
      if (cmd.rest) begin
         for (int i = 0; i < BookDepth; i++) begin
            if (!ins_before[i]) begin
               if (i == 0 || ins_before[i-1]) begin
                  id_ff[own][i] <= q_ff.order_id;
                  px_ff[own][i] <= q_ff.limit_price;
                  lf_ff[own][i] <= rem_ff;
               end else begin
                  id_ff[own][i] <= id_ff[own][i-1];
                  px_ff[own][i] <= px_ff[own][i-1];
                  lf_ff[own][i] <= lf_ff[own][i-1];
               end
            end
         end
      end
      if (cmd.cancel && sts.found) begin
         for (int i = 0; i < BookDepth - 1; i++) begin
            if (at_or_after[i]) begin
               id_ff[cbook][i] <= id_ff[cbook][i+1];
               px_ff[cbook][i] <= px_ff[cbook][i+1];
               lf_ff[cbook][i] <= lf_ff[cbook][i+1];
            end
         end
      end
      if (cmd.emit) begin
         out_ff.kind <= cmd.kind;
         out_ff.last <= (cmd.kind != KIND_TRADE);
         if (cmd.kind == KIND_TRADE) begin
            out_ff.buyer_id <= (q_ff.side == SIDE_BUY) ? q_ff.order_id : id_ff[opp][0];
            out_ff.seller_id <= (q_ff.side == SIDE_BUY) ? id_ff[opp][0] : q_ff.order_id;
            out_ff.trade_price <= head_px;
            out_ff.amount <= fill_q;
         end else begin
            out_ff.buyer_id <= '0;
            out_ff.seller_id <= '0;
            out_ff.trade_price <= '0;
            if (cmd.kind == KIND_DONE || cmd.kind == KIND_RESTED || cmd.kind == KIND_FULL)
               out_ff.amount <= rem_ff;
            else
               out_ff.amount <= '0;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   // The valid bits of each book stay a gap-free prefix.
   a_prefix0: assert property (@(posedge clock) disable iff (reset)
      ((vld_ff[0] & (vld_ff[0] + 1'b1)) == '0)) else $error("bid valid not a prefix");
   a_prefix1: assert property (@(posedge clock) disable iff (reset)
      ((vld_ff[1] & (vld_ff[1] + 1'b1)) == '0)) else $error("ask valid not a prefix");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy) else $error("result overwritten");
endmodule
`default_nettype wire

### rtl/lom_control.sv
// Controller of the limit order matcher: sequences fills, resting and cancels.
`default_nettype none
module lom_control
   import lom_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [1:0] {S_IDLE, S_WORK} state_type;
   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.kind = KIND_DONE;
      cmd.load = req_valid && (state_ff == S_IDLE);
      if (state_ff == S_WORK && !sts.out_busy) begin
         cmd.emit = 1'b1;
         if (sts.is_cancel) begin
            cmd.cancel = 1'b1;
            cmd.kind = sts.found ? KIND_CANCELLED : KIND_NOT_FOUND;
         end else if (sts.crosses) begin
            cmd.fill = 1'b1;
            cmd.kind = KIND_TRADE;
         end else if (sts.rem_zero || sts.is_market) begin
            cmd.kind = KIND_DONE;
         end else if (sts.own_full) begin
            cmd.kind = KIND_FULL;
         end else begin
            cmd.rest = 1'b1;
            cmd.kind = KIND_RESTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_WORK;
            S_WORK: if (cmd.emit && cmd.kind != KIND_TRADE) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.fill, cmd.rest, cmd.cancel}) <= 1) else $error("two book ops");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.emit) else $error("load during work");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind != KIND_TRADE) |=> req_ready) else $error("no return to idle");
endmodule
`default_nettype wire

### tb/limit_order_matcher_core_tb.sv
// Self-checking testbench for the limit order matcher core with its book predictor.
`timescale 1ns / 100ps
`default_nettype none
module limit_order_matcher_core_tb;
   import lom_pkg::*;

   localparam int BOOK_BID = 0;
   localparam int BOOK_ASK = 1;
   localparam logic SIDE_SELL = 1'b1;
   localparam logic TYPE_LIMIT = 1'b0;
   localparam logic TYPE_MARKET = 1'b1;

   // Mirrors both books in priority order and queues the results each request causes.
   class match_scoreboard;
      logic [31:0] ids[2][BookDepth];
      logic [31:0] px[2][BookDepth];
      logic [31:0] lft[2][BookDepth];
      int          cnt[2];
      rsp_type     due_q[$];
      int          errors;
      int          trades, rests, fulls, cancels, misses, requests;

      function void push(logic [2:0] kind, logic [31:0] buyer, logic [31:0] seller,
                         logic [31:0] price, logic [31:0] amt, logic last);
         rsp_type r;
         r = '{kind: kind, buyer_id: buyer, seller_id: seller, trade_price: price,
               amount: amt, last: last};
         due_q = {due_q, r};
      endfunction

      function void remove(int bk, int pos);
         for (int i = pos; i + 1 < cnt[bk]; i++) begin
            ids[bk][i] = ids[bk][i + 1];
            px[bk][i] = px[bk][i + 1];
            lft[bk][i] = lft[bk][i + 1];
         end
         cnt[bk]--;
      endfunction

      function void note_request(req_type r);
         int own, opp, pos;
         bit found, crosses;
         logic [31:0] rem, p, fill;
         requests++;
         if (r.operation == OP_CANCEL) begin
            found = 0;
            // The bid book is searched before the ask book.
            for (int bk = BOOK_BID; bk <= BOOK_ASK; bk++)
               for (int i = 0; i < cnt[bk]; i++)
                  if (!found && ids[bk][i] == r.order_id) begin
                     remove(bk, i);
                     found = 1;
                  end
            if (found) begin
               cancels++;
               push(KIND_CANCELLED, 0, 0, 0, 0, 1'b1);
            end else begin
               misses++;
               push(KIND_NOT_FOUND, 0, 0, 0, 0, 1'b1);
            end
            return;
         end
         own = (r.side == SIDE_BUY) ? BOOK_BID : BOOK_ASK;
         opp = (r.side == SIDE_BUY) ? BOOK_ASK : BOOK_BID;
         rem = r.quantity;
         while (rem != 0 && cnt[opp] > 0) begin
            p = px[opp][0];
            crosses = (r.order_type == TYPE_MARKET) ||
                      ((r.side == SIDE_BUY) ? (r.limit_price >= p) : (p >= r.limit_price));
            if (!crosses) break;
            fill = (rem < lft[opp][0]) ? rem : lft[opp][0];
            if (r.side == SIDE_BUY) push(KIND_TRADE, r.order_id, ids[opp][0], p, fill, 1'b0);
            else push(KIND_TRADE, ids[opp][0], r.order_id, p, fill, 1'b0);
            trades++;
            rem -= fill;
            lft[opp][0] -= fill;
            if (lft[opp][0] == 0) remove(opp, 0);
         end
         if (rem == 0 || r.order_type == TYPE_MARKET) begin
            push(KIND_DONE, 0, 0, 0, rem, 1'b1);
         end else if (cnt[own] >= BookDepth) begin
            fulls++;
            push(KIND_FULL, 0, 0, 0, rem, 1'b1);
         end else begin
            pos = 0;
            while (pos < cnt[own] && ((r.side == SIDE_BUY) ? (px[own][pos] >= r.limit_price)
                                                           : (px[own][pos] <= r.limit_price)))
               pos++;
            for (int i = cnt[own]; i > pos; i--) begin
               ids[own][i] = ids[own][i - 1];
               px[own][i] = px[own][i - 1];
               lft[own][i] = lft[own][i - 1];
            end
            ids[own][pos] = r.order_id;
            px[own][pos] = r.limit_price;
            lft[own][pos] = rem;
            cnt[own]++;
            rests++;
            push(KIND_RESTED, 0, 0, 0, rem, 1'b1);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: %p", got);
            return;
         end
         exp = due_q.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %p, got %p", exp, got);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   match_scoreboard book_sb = new();
   int          stall_cycles;
   logic [31:0] placed_ids[$];

   limit_order_matcher_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) book_sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) book_sb.check_result(rsp_data);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // The receiver stalls at random; a stretch requested through stall_cycles holds it off.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (stall_cycles > 0) begin
            rsp_ready <= 1'b0;
            stall_cycles--;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send(bit no_gap, logic op, logic side, logic otype, logic [31:0] id,
                       logic [31:0] price, logic [31:0] qty);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, side: side, order_type: otype, order_id: id,
                    limit_price: price, quantity: qty};
      if (op == OP_ADD) placed_ids = {placed_ids, id};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic add(logic side, logic otype, logic [31:0] id, logic [31:0] price,
                      logic [31:0] qty);
      send(0, OP_ADD, side, otype, id, price, qty);
   endtask

   task automatic cancel(logic [31:0] id);
      send(0, OP_CANCEL, 1'($urandom), 1'($urandom), id, $urandom, $urandom);
   endtask

   task automatic random_request(bit no_gap);
      int r;
      logic [31:0] price, qty;
      r = $urandom_range(0, 99);
      price = ($urandom_range(0, 19) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 40) - 20;
      case ($urandom_range(0, 9))
         0: qty = 0;
         1: qty = $urandom;
         default: qty = $urandom_range(1, 50);
      endcase
      if (r < 55)
         send(no_gap, OP_ADD, 1'($urandom), TYPE_LIMIT, $urandom, price, qty);
      else if (r < 67)
         send(no_gap, OP_ADD, 1'($urandom), TYPE_MARKET, $urandom, $urandom, qty);
      else if (r < 93 && placed_ids.size() > 0)
         send(no_gap, OP_CANCEL, 1'($urandom), 1'($urandom),
              placed_ids[$urandom_range(0, placed_ids.size() - 1)], $urandom, $urandom);
      else
         send(no_gap, OP_CANCEL, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom);
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty books, extreme fields, market orders, time priority, duplicates.
      cancel(32'hFFFF_FFFF);
      add(SIDE_BUY, TYPE_LIMIT, 32'd1, 32'd0, 32'd5);
      add(SIDE_BUY, TYPE_LIMIT, 32'd2, 32'd500, 32'd0);
      add(SIDE_SELL, TYPE_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add(SIDE_SELL, TYPE_MARKET, 32'd3, 32'd0, 32'd3);
      add(SIDE_SELL, TYPE_MARKET, 32'd4, 32'hFFFF_FFFF, 32'd10);
      add(SIDE_BUY, TYPE_MARKET, 32'd5, 32'd0, 32'd7);
      add(SIDE_SELL, TYPE_LIMIT, 32'd10, 32'd100, 32'd10);
      add(SIDE_SELL, TYPE_LIMIT, 32'd11, 32'd100, 32'd5);
      add(SIDE_SELL, TYPE_LIMIT, 32'd12, 32'd90, 32'd4);
      add(SIDE_BUY, TYPE_LIMIT, 32'd13, 32'd100, 32'd16);
      cancel(32'hFFFF_FFFF);
      add(SIDE_BUY, TYPE_LIMIT, 32'hAAAA_5555, 32'd50, 32'd8);
      cancel(32'hAAAA_5555);
      add(SIDE_SELL, TYPE_LIMIT, 32'd14, 32'd99, 32'd1);
      add(SIDE_BUY, TYPE_LIMIT, 32'd15, 32'd98, 32'd2);
      add(SIDE_BUY, TYPE_MARKET, 32'd16, 32'd0, 32'd20);
      add(SIDE_BUY, TYPE_LIMIT, 32'd7, 32'd10, 32'd4);
      add(SIDE_SELL, TYPE_LIMIT, 32'd7, 32'd2000, 32'd6);
      cancel(32'd7);
      cancel(32'd7);
      add(SIDE_SELL, TYPE_MARKET, 32'd17, 32'd0, 32'hFFFF_FFFF);

      // Random part, with bursts that fill one book and a long receiver hold-off.
      for (int n = 0; n < 255; n++) begin
         if (n == 120 || n == 230) begin
            // Resting orders far from the market fill a book until it overflows.
            for (int k = 0; k < 36; k++)
               send(1'($urandom_range(0, 1)), OP_ADD, (n == 120) ? SIDE_BUY : SIDE_SELL,
                    TYPE_LIMIT, $urandom,
                    (n == 120) ? 32'($urandom_range(1, 50)) : 32'($urandom_range(5000, 6000)),
                    $urandom_range(1, 20));
            add((n == 120) ? SIDE_SELL : SIDE_BUY, TYPE_MARKET, $urandom, 0, 32'd2000);
         end
         if (n == 200) stall_cycles = 400;
         random_request(n >= 200 && n < 240);
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (book_sb.due_q.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (book_sb.due_q.size() != 0) begin
         $display("%0d results never arrived", book_sb.due_q.size());
         book_sb.errors++;
      end
      $display("requests %0d: trades %0d, rested %0d, dropped as book full %0d",
               book_sb.requests, book_sb.trades, book_sb.rests, book_sb.fulls);
      $display("cancels found %0d, not found %0d, mismatches %0d",
               book_sb.cancels, book_sb.misses, book_sb.errors);
      if (book_sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
